### hw/rtl/awts_pkg.sv
package awts_pkg;

    localparam int TRI_DEPTH = 1024;
    localparam int IDX_W     = 10;
    localparam int CNT_W     = 11;
    localparam int AREA_W    = 48;
    localparam int RAD_W     = 70;
    localparam int ROOT_W    = 35;

    typedef enum logic [1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2,
        OP_NOP    = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    localparam logic [1:0] CORNER_A    = 2'd0;
    localparam logic [1:0] CORNER_B    = 2'd1;
    localparam logic [1:0] CORNER_C    = 2'd2;
    localparam logic [1:0] CORNER_NONE = 2'd3;

    typedef logic signed [15:0] coord_t;
    typedef logic [2:0][15:0] point_t;
    typedef logic [2:0][2:0][15:0] vrow_t;

    typedef struct packed {
        opcode_t     opcode;
        logic [1:0]  corner;
        coord_t      x_in;
        coord_t      y_in;
        coord_t      z_in;
        logic [15:0] select_rand;
        logic [15:0] r1_rand;
        logic [15:0] r2_rand;
    } cmd_t;

    typedef struct packed {
        status_t     status;
        logic [9:0]  triangle_index;
        coord_t      x_out;
        coord_t      y_out;
        coord_t      z_out;
    } res_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CROSS,
        S_SQ,
        S_RGO,
        S_ROOT,
        S_COMMIT,
        S_SEL,
        S_SRCH,
        S_SCMP,
        S_SWAIT,
        S_WGT,
        S_BLEND,
        S_DONE
    } state_t;

endpackage

### hw/rtl/awts_if.sv
interface awts_cmd_if;
    logic           valid;
    logic           ready;
    awts_pkg::cmd_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface awts_res_if;
    logic           valid;
    logic           ready;
    awts_pkg::res_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### hw/rtl/awts_isqrt.sv
module awts_isqrt (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [awts_pkg::RAD_W-1:0]    rad,
    output logic                          busy,
    output logic [awts_pkg::ROOT_W-1:0]   root
);

    localparam logic [5:0] LAST = 6'(awts_pkg::ROOT_W - 1);

    logic                          busy_reg;
    logic [5:0]                    cnt_reg;
    logic [36:0]                   rem_reg;
    logic [awts_pkg::ROOT_W-1:0]   root_reg;
    logic [awts_pkg::RAD_W-1:0]    rad_reg;
    logic [38:0]                   rem_sh;
    logic [38:0]                   trial;
    logic [38:0]                   rem_next;
    logic                          ge;

    always_comb
    begin
        rem_sh   = {rem_reg, rad_reg[awts_pkg::RAD_W-1 -: 2]};
        trial    = {2'b00, root_reg, 2'b01};
        ge       = (rem_sh >= trial);
        rem_next = ge ? (rem_sh - trial) : rem_sh;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 6'd1;
            if (cnt_reg == LAST)
            begin
                busy_reg <= 1'b0;
            end
        end
    end

    // one result bit per cycle, two radicand bits shifted in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg  <= '0;
            root_reg <= '0;
            rad_reg  <= rad;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next[36:0];
            root_reg <= {root_reg[awts_pkg::ROOT_W-2:0], ge};
            rad_reg  <= {rad_reg[awts_pkg::RAD_W-3:0], 2'b00};
        end
    end

    assign busy = busy_reg;
    assign root = root_reg;

endmodule

### hw/rtl/area_weighted_triangle_sampler.sv
// channel  dir  beat
// cmd      in   opcode, corner, x_in/y_in/z_in, select_rand, r1_rand, r2_rand
// res      out  status, triangle_index, x_out/y_out/z_out
//
// Corner A and B loads, clears, no-ops and rejected beats are answered straight from idle.
// A commit forms the cross product and squared norm on the shared 36x18
// multiplier, then takes the 35-step square root of the norm.
// A sample runs the 35-step square root beside the binary search on the
// cumulative memory, then nine blend products.
// rst_n clears the table count, area total and staged corners; memories hold.
// cmd is taken only in idle with the result register free or being drained.
module area_weighted_triangle_sampler (
    input  logic              clk,
    input  logic              rst_n,
    awts_cmd_if.sink          cmd,
    awts_res_if.source        res
);

    awts_pkg::state_t   state_reg, state_next;
    logic [2:0]         cnt_reg;
    logic [1:0]         ax_reg;
    logic               ph_reg;

    awts_pkg::point_t   a_reg, b_reg, c_reg;
    logic [10:0]        count_reg;
    logic [47:0]        total_reg;
    logic signed [34:0] cross_reg [3];
    logic [71:0]        acc_reg;
    logic signed [53:0] prod_reg;
    logic [15:0]        sel_reg, r2_reg;
    logic [47:0]        r_reg;
    logic [10:0]        lo_reg, hi_reg;
    logic [9:0]         idx_reg;
    logic [33:0]        wb_reg, wc_reg;
    awts_pkg::point_t   pt_reg;
    logic               res_valid_reg;
    awts_pkg::res_t     res_reg;

    logic [47:0]        cum_mem [awts_pkg::TRI_DEPTH];
    logic [47:0]        cum_rd;
    awts_pkg::vrow_t    vtx_mem [awts_pkg::TRI_DEPTH];
    awts_pkg::vrow_t    vtx_rd;

    logic signed [16:0] u [3];
    logic signed [16:0] v [3];
    logic [34:0]        neg_cross;
    logic [33:0]        mag;
    logic [10:0]        mid;
    logic [10:0]        count_m1;
    logic [15:0]        s_val;
    logic [33:0]        wa;
    logic [48:0]        t_sum;
    logic [47:0]        t_sat;
    logic [71:0]        prod_z, prod_s, blend_sum, sel_sum;
    logic               out_free, cmd_fire, is_full, is_mac;
    awts_pkg::point_t   cmd_pt;

    logic                          res_load;
    awts_pkg::res_t                res_next;
    logic                          sq_start, sq_busy;
    logic [awts_pkg::RAD_W-1:0]    sq_rad;
    logic [awts_pkg::ROOT_W-1:0]   sq_root;
    logic signed [35:0]            mul_a;
    logic signed [17:0]            mul_b;
    logic [1:0]                    mac_dst;
    logic                          mac_neg;
    logic [5:0]                    mac_sh;

    awts_isqrt u_isqrt (
        .clk   (clk),
        .rst_n (rst_n),
        .start (sq_start),
        .rad   (sq_rad),
        .busy  (sq_busy),
        .root  (sq_root)
    );

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            u[i] = {b_reg[i][15], b_reg[i]} - {a_reg[i][15], a_reg[i]};
            v[i] = {c_reg[i][15], c_reg[i]} - {a_reg[i][15], a_reg[i]};
        end
        neg_cross = -cross_reg[ax_reg];
        mag       = cross_reg[ax_reg][34] ? neg_cross[33:0] : cross_reg[ax_reg][33:0];
        mid       = lo_reg + ((hi_reg - lo_reg) >> 1);
        count_m1  = count_reg - 11'd1;
        s_val     = sq_root[15:0];
        wa        = {1'b0, (17'h10000 - {1'b0, s_val}), 16'h0000};
        t_sum     = {1'b0, total_reg} + {14'b0, sq_root};
        t_sat     = t_sum[48] ? '1 : t_sum[47:0];
        prod_z    = {18'b0, prod_reg};
        prod_s    = {{18{prod_reg[53]}}, prod_reg};
        blend_sum = acc_reg + prod_s;
        sel_sum   = acc_reg + (prod_z << mac_sh);
        out_free  = !res_valid_reg || res.ready;
        cmd_fire  = cmd.valid && cmd.ready;
        is_full   = count_reg[10];
        is_mac    = (state_reg == awts_pkg::S_CROSS) || (state_reg == awts_pkg::S_SQ)
                 || (state_reg == awts_pkg::S_SEL) || (state_reg == awts_pkg::S_WGT)
                 || (state_reg == awts_pkg::S_BLEND);
        cmd_pt    = {cmd.data.z_in, cmd.data.y_in, cmd.data.x_in};
    end

    // multiplier operand selection
    always_comb
    begin
        mul_a   = '0;
        mul_b   = '0;
        mac_dst = 2'd0;
        mac_neg = 1'b0;
        mac_sh  = '0;
        unique case (state_reg)
            awts_pkg::S_CROSS:
            begin
                unique case (cnt_reg)
                    3'd1:    begin mul_a = 36'(u[2]); mul_b = 18'(v[1]); mac_neg = 1'b1; end
                    3'd2:    begin mul_a = 36'(u[2]); mul_b = 18'(v[0]); mac_dst = 2'd1; end
                    3'd3:
                    begin
                        mul_a = 36'(u[0]); mul_b = 18'(v[2]); mac_dst = 2'd1; mac_neg = 1'b1;
                    end
                    3'd4:    begin mul_a = 36'(u[0]); mul_b = 18'(v[1]); mac_dst = 2'd2; end
                    3'd5:
                    begin
                        mul_a = 36'(u[1]); mul_b = 18'(v[0]); mac_dst = 2'd2; mac_neg = 1'b1;
                    end
                    default: begin mul_a = 36'(u[1]); mul_b = 18'(v[2]); end
                endcase
            end
            awts_pkg::S_SQ:
            begin
                unique case (cnt_reg)
                    3'd1:    begin mul_a = {19'b0, mag[33:17]}; mul_b = {1'b0, mag[16:0]};
                                   mac_sh = 6'd18; end
                    3'd2:    begin mul_a = {19'b0, mag[33:17]}; mul_b = {1'b0, mag[33:17]};
                                   mac_sh = 6'd34; end
                    default: begin mul_a = {19'b0, mag[16:0]}; mul_b = {1'b0, mag[16:0]}; end
                endcase
            end
            awts_pkg::S_SEL:
            begin
                mul_b = {2'b00, sel_reg};
                if (cnt_reg[0])
                begin
                    mul_a  = {12'b0, total_reg[47:24]};
                    mac_sh = 6'd24;
                end
                else
                begin
                    mul_a = {12'b0, total_reg[23:0]};
                end
            end
            awts_pkg::S_WGT:
            begin
                mul_a = {20'b0, s_val};
                mul_b = cnt_reg[0] ? {2'b00, r2_reg} : {1'b0, (17'h10000 - {1'b0, r2_reg})};
            end
            awts_pkg::S_BLEND:
            begin
                unique case (cnt_reg)
                    3'd1:    mul_a = {2'b00, wb_reg};
                    3'd2:    mul_a = {2'b00, wc_reg};
                    default: mul_a = {2'b00, wa};
                endcase
                mul_b = 18'($signed(vtx_rd[cnt_reg[1:0]][ax_reg]));
            end
            default:
            begin
                mul_a = '0;
            end
        endcase
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            awts_pkg::S_IDLE:
            begin
                if (cmd_fire && cmd.data.opcode == awts_pkg::OP_LOAD
                        && cmd.data.corner == awts_pkg::CORNER_C && !is_full)
                begin
                    state_next = awts_pkg::S_CROSS;
                end
                else if (cmd_fire && cmd.data.opcode == awts_pkg::OP_SAMPLE
                        && count_reg != '0)
                begin
                    state_next = awts_pkg::S_SEL;
                end
            end
            awts_pkg::S_CROSS:
                if (ph_reg && cnt_reg == 3'd5) state_next = awts_pkg::S_SQ;
            awts_pkg::S_SQ:
                if (ph_reg && cnt_reg == 3'd2 && ax_reg == 2'd2) state_next = awts_pkg::S_RGO;
            awts_pkg::S_RGO:
                state_next = awts_pkg::S_ROOT;
            awts_pkg::S_ROOT:
                if (!sq_busy) state_next = awts_pkg::S_COMMIT;
            awts_pkg::S_COMMIT:
                if (out_free) state_next = awts_pkg::S_IDLE;
            awts_pkg::S_SEL:
                if (ph_reg && cnt_reg == 3'd1) state_next = awts_pkg::S_SRCH;
            awts_pkg::S_SRCH:
                state_next = (lo_reg < hi_reg) ? awts_pkg::S_SCMP : awts_pkg::S_SWAIT;
            awts_pkg::S_SCMP:
                state_next = awts_pkg::S_SRCH;
            awts_pkg::S_SWAIT:
                if (!sq_busy) state_next = awts_pkg::S_WGT;
            awts_pkg::S_WGT:
                if (ph_reg && cnt_reg == 3'd1) state_next = awts_pkg::S_BLEND;
            awts_pkg::S_BLEND:
                if (ph_reg && cnt_reg == 3'd2 && ax_reg == 2'd2) state_next = awts_pkg::S_DONE;
            awts_pkg::S_DONE:
                if (out_free) state_next = awts_pkg::S_IDLE;
            default:
                state_next = awts_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd.ready = (state_reg == awts_pkg::S_IDLE) && out_free;
        res_load  = 1'b0;
        res_next  = '0;
        sq_start  = 1'b0;
        sq_rad    = {38'b0, cmd.data.r1_rand, 16'h0000};
        unique case (state_reg)
            awts_pkg::S_IDLE:
            begin
                sq_start = cmd_fire && cmd.data.opcode == awts_pkg::OP_SAMPLE;
                priority if (cmd.data.opcode == awts_pkg::OP_LOAD
                        && cmd.data.corner == awts_pkg::CORNER_C && !is_full)
                begin
                    res_load = 1'b0;
                end
                else if (cmd.data.opcode == awts_pkg::OP_SAMPLE && count_reg != '0)
                begin
                    res_load = 1'b0;
                end
                else
                begin
                    res_load = cmd_fire;
                    if (cmd.data.opcode == awts_pkg::OP_LOAD
                            && cmd.data.corner != awts_pkg::CORNER_NONE && is_full)
                    begin
                        res_next.status = awts_pkg::ST_FULL;
                    end
                    else if (cmd.data.opcode == awts_pkg::OP_SAMPLE)
                    begin
                        res_next.status = awts_pkg::ST_EMPTY;
                    end
                end
            end
            awts_pkg::S_RGO:
            begin
                sq_start = 1'b1;
                sq_rad   = acc_reg[awts_pkg::RAD_W-1:0];
            end
            awts_pkg::S_COMMIT:
            begin
                res_load                = out_free;
                res_next.triangle_index = count_reg[9:0];
            end
            awts_pkg::S_DONE:
            begin
                res_load                = out_free;
                res_next.triangle_index = idx_reg;
                res_next.x_out          = pt_reg[0];
                res_next.y_out          = pt_reg[1];
                res_next.z_out          = pt_reg[2];
            end
            default:
            begin
                res_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= awts_pkg::S_IDLE;
            cnt_reg       <= '0;
            ax_reg        <= '0;
            ph_reg        <= 1'b0;
            count_reg     <= '0;
            total_reg     <= '0;
            a_reg         <= '0;
            b_reg         <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_next != state_reg)
            begin
                cnt_reg <= '0;
                ax_reg  <= '0;
                ph_reg  <= 1'b0;
            end
            else if (is_mac)
            begin
                ph_reg <= ~ph_reg;
                if (ph_reg)
                begin
                    if ((state_reg == awts_pkg::S_SQ || state_reg == awts_pkg::S_BLEND)
                            && cnt_reg == 3'd2)
                    begin
                        cnt_reg <= '0;
                        ax_reg  <= ax_reg + 2'd1;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 3'd1;
                    end
                end
            end

            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            if (cmd_fire && cmd.data.opcode == awts_pkg::OP_LOAD && !is_full)
            begin
                if (cmd.data.corner == awts_pkg::CORNER_A) a_reg <= cmd_pt;
                if (cmd.data.corner == awts_pkg::CORNER_B) b_reg <= cmd_pt;
            end
            if (cmd_fire && cmd.data.opcode == awts_pkg::OP_CLEAR)
            begin
                count_reg <= '0;
                total_reg <= '0;
                a_reg     <= '0;
                b_reg     <= '0;
            end
            if (state_reg == awts_pkg::S_COMMIT && out_free)
            begin
                total_reg <= t_sat;
                count_reg <= count_reg + 11'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
        if (res_load)
        begin
            res_reg <= res_next;
        end
        if (cmd_fire)
        begin
            c_reg   <= cmd_pt;
            sel_reg <= cmd.data.select_rand;
            r2_reg  <= cmd.data.r2_rand;
            acc_reg <= '0;
            for (int i = 0; i < 3; i++)
            begin
                cross_reg[i] <= '0;
            end
        end
        if (ph_reg)
        begin
            unique case (state_reg)
                awts_pkg::S_CROSS:
                    cross_reg[mac_dst] <= mac_neg ? cross_reg[mac_dst] - prod_reg[34:0]
                                                  : cross_reg[mac_dst] + prod_reg[34:0];
                awts_pkg::S_SQ:
                    acc_reg <= sel_sum;
                awts_pkg::S_SEL:
                begin
                    acc_reg <= sel_sum;
                    if (cnt_reg == 3'd1)
                    begin
                        r_reg  <= sel_sum[63:16];
                        lo_reg <= '0;
                        hi_reg <= count_reg;
                    end
                end
                awts_pkg::S_WGT:
                begin
                    if (cnt_reg[0]) wc_reg <= prod_reg[33:0];
                    else            wb_reg <= prod_reg[33:0];
                    acc_reg <= '0;
                end
                awts_pkg::S_BLEND:
                begin
                    // close an axis: floor by dropping the 32 fraction bits
                    if (cnt_reg == 3'd2)
                    begin
                        pt_reg[ax_reg] <= blend_sum[47:32];
                        acc_reg        <= '0;
                    end
                    else
                    begin
                        acc_reg <= blend_sum;
                    end
                end
                default:
                begin
                end
            endcase
        end
        if (state_reg == awts_pkg::S_SCMP)
        begin
            if (cum_rd < r_reg) lo_reg <= mid + 11'd1;
            else                hi_reg <= mid;
        end
        if (state_reg == awts_pkg::S_SRCH && !(lo_reg < hi_reg))
        begin
            idx_reg <= (lo_reg >= count_reg) ? count_m1[9:0] : lo_reg[9:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == awts_pkg::S_COMMIT && out_free)
        begin
            cum_mem[count_reg[9:0]] <= t_sat;
            vtx_mem[count_reg[9:0]] <= {c_reg, b_reg, a_reg};
        end
        cum_rd <= cum_mem[mid[9:0]];
        vtx_rd <= vtx_mem[idx_reg];
    end

    assign res.valid = res_valid_reg;
    assign res.data  = res_reg;

endmodule

### hw/rtl/awts_checker.sv
module awts_checker (
    input  logic        clk,
    input  logic        rst_n,
    awts_cmd_if.sink    cmd,
    awts_res_if.source  res
);

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> res.valid)
        else $error("result beat dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && !res.ready |=> $stable(res.data))
        else $error("result beat changed while stalled");

    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.valid && cmd.ready |-> !res.valid || res.ready)
        else $error("command taken while result register blocked");

    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res.valid && res.data.status != awts_pkg::ST_OK
        |-> res.data.x_out == '0 && res.data.y_out == '0 && res.data.z_out == '0
            && res.data.triangle_index == '0)
        else $error("error beat carries nonzero fields");

endmodule

bind area_weighted_triangle_sampler awts_checker u_awts_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .res   (res)
);

### sim/tb_area_weighted_triangle_sampler.sv
module tb_area_weighted_triangle_sampler;

    localparam int NUM_RANDOM = 420;
    localparam logic [47:0] AREA_SAT = 48'hFFFF_FFFF_FFFF;

    logic clk;
    logic rst_n;
    bit   failed;
    bit   stim_done;
    bit   hold_off;

    awts_cmd_if cmd_ch ();
    awts_res_if res_ch ();

    area_weighted_triangle_sampler DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (cmd_ch.sink),
        .res   (res_ch.source)
    );

    // Predicts the sampler's results and holds them until the matching beat arrives.
    class sampler_scoreboard;
        logic signed [15:0] corners[0:3071][0:2];
        logic [47:0]        cum_area[0:1023];
        int                 tri_count;
        logic [47:0]        area_total;
        logic signed [15:0] staged[0:1][0:2];
        awts_pkg::res_t     pending_results[$];

        function new();
            tri_count = 0;
            area_total = '0;
            foreach (staged[i, j]) staged[i][j] = '0;
        endfunction

        function logic [63:0] wide_sqrt(logic [127:0] v);
            logic [63:0]  r;
            logic [63:0]  c;
            logic [127:0] sq;
            r = '0;
            for (int b = 50; b >= 0; b--) begin
                c = r | (64'd1 << b);
                sq = 128'(c) * 128'(c);
                if (sq <= v) r = c;
            end
            return r;
        endfunction

        function logic [47:0] tri_area2(logic signed [15:0] a[0:2],
                                        logic signed [15:0] b[0:2],
                                        logic signed [15:0] c[0:2]);
            longint       u[3];
            longint       v[3];
            longint       cr[3];
            logic [127:0] acc;
            for (int i = 0; i < 3; i++) begin
                u[i] = longint'(b[i]) - longint'(a[i]);
                v[i] = longint'(c[i]) - longint'(a[i]);
            end
            cr[0] = u[1] * v[2] - u[2] * v[1];
            cr[1] = u[2] * v[0] - u[0] * v[2];
            cr[2] = u[0] * v[1] - u[1] * v[0];
            acc = '0;
            for (int i = 0; i < 3; i++) begin
                logic [63:0] m;
                m = cr[i] < 0 ? 64'(-cr[i]) : 64'(cr[i]);
                acc += 128'(m) * 128'(m);
            end
            return 48'(wide_sqrt(acc));
        endfunction

        function void note_command(awts_pkg::cmd_t c);
            awts_pkg::res_t r;
            logic signed [15:0] p[0:2];
            r = '0;
            r.status = awts_pkg::ST_OK;
            p[0] = c.x_in;
            p[1] = c.y_in;
            p[2] = c.z_in;
            if (c.opcode == awts_pkg::OP_LOAD && c.corner != awts_pkg::CORNER_NONE) begin
                if (tri_count >= awts_pkg::TRI_DEPTH) begin
                    r.status = awts_pkg::ST_FULL;
                end else if (c.corner != awts_pkg::CORNER_C) begin
                    for (int i = 0; i < 3; i++) staged[c.corner][i] = p[i];
                end else begin
                    logic [48:0] t;
                    for (int i = 0; i < 3; i++) begin
                        corners[3*tri_count][i]   = staged[0][i];
                        corners[3*tri_count+1][i] = staged[1][i];
                        corners[3*tri_count+2][i] = p[i];
                    end
                    t = 49'(area_total) + 49'(tri_area2(staged[0], staged[1], p));
                    area_total = t[48] ? AREA_SAT : t[47:0];
                    cum_area[tri_count] = area_total;
                    r.triangle_index = 10'(tri_count);
                    tri_count++;
                end
            end else if (c.opcode == awts_pkg::OP_SAMPLE) begin
                if (tri_count == 0) begin
                    r.status = awts_pkg::ST_EMPTY;
                end else begin
                    logic [63:0]        pos;
                    int                 lo, hi, mid;
                    logic [63:0]        s;
                    logic signed [63:0] wa, wb, wc, acc;
                    pos = (64'(c.select_rand) * 64'(area_total)) >> 16;
                    lo = 0;
                    hi = tri_count;
                    while (lo < hi) begin
                        mid = lo + (hi - lo) / 2;
                        if (64'(cum_area[mid]) < pos) lo = mid + 1; else hi = mid;
                    end
                    if (lo >= tri_count) lo = tri_count - 1;
                    r.triangle_index = 10'(lo);
                    s = wide_sqrt(128'(c.r1_rand) << 16);
                    wa = (64'd65536 - s) << 16;
                    wb = s * (64'd65536 - 64'(c.r2_rand));
                    wc = s * 64'(c.r2_rand);
                    for (int i = 0; i < 3; i++) begin
                        acc = wa * corners[3*lo][i] + wb * corners[3*lo+1][i]
                            + wc * corners[3*lo+2][i];
                        p[i] = 16'(acc >>> 32);
                    end
                    r.x_out = p[0];
                    r.y_out = p[1];
                    r.z_out = p[2];
                end
            end else if (c.opcode == awts_pkg::OP_CLEAR) begin
                tri_count = 0;
                area_total = '0;
                foreach (staged[i, j]) staged[i][j] = '0;
            end
            pending_results.push_back(r);
        endfunction

        function bit check_result(awts_pkg::res_t got);
            awts_pkg::res_t exp_r;
            bit   bad;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $time, got);
                return 1;
            end
            exp_r = pending_results.pop_front();
            bad = 0;
            if (got.status !== exp_r.status) begin
                $display("%0t: status exp %0d got %0d", $time, exp_r.status, got.status);
                bad = 1;
            end
            if (got.triangle_index !== exp_r.triangle_index) begin
                $display("%0t: triangle_index exp %0d got %0d", $time,
                         exp_r.triangle_index, got.triangle_index);
                bad = 1;
            end
            if (got.x_out !== exp_r.x_out) begin
                $display("%0t: x_out exp %0d got %0d", $time, exp_r.x_out, got.x_out);
                bad = 1;
            end
            if (got.y_out !== exp_r.y_out) begin
                $display("%0t: y_out exp %0d got %0d", $time, exp_r.y_out, got.y_out);
                bad = 1;
            end
            if (got.z_out !== exp_r.z_out) begin
                $display("%0t: z_out exp %0d got %0d", $time, exp_r.z_out, got.z_out);
                bad = 1;
            end
            return bad;
        endfunction
    endclass

    sampler_scoreboard sb;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 45) return 0;
        if (roll < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Present one beat, hold it until accepted, then, when gaps is set, idle a random gap.
    task automatic send_beat(awts_pkg::cmd_t c, bit gaps);
        int gap;
        cmd_ch.valid <= 1'b1;
        cmd_ch.data  <= c;
        @(posedge clk);
        while (!cmd_ch.ready) @(posedge clk);
        sb.note_command(c);
        gap = gaps ? pick_gap() : 0;
        if (gap > 0) begin
            cmd_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    function awts_pkg::cmd_t make_cmd(awts_pkg::opcode_t op, logic [1:0] cn);
        awts_pkg::cmd_t c;
        c = '0;
        c.opcode = op;
        c.corner = cn;
        c.x_in = 16'($urandom);
        c.y_in = 16'($urandom);
        c.z_in = 16'($urandom);
        c.select_rand = 16'($urandom);
        c.r1_rand = 16'($urandom);
        c.r2_rand = 16'($urandom);
        return c;
    endfunction

    function awts_pkg::cmd_t corner_cmd(logic [1:0] cn, int x, int y, int z);
        awts_pkg::cmd_t c;
        c = make_cmd(awts_pkg::OP_LOAD, cn);
        c.x_in = 16'(x);
        c.y_in = 16'(y);
        c.z_in = 16'(z);
        return c;
    endfunction

    task automatic load_random_triangle(bit gaps);
        awts_pkg::cmd_t c;
        int   span;
        span = $urandom_range(0, 3) == 0 ? 32767 : $urandom_range(4, 2000);
        for (int k = 0; k < 3; k++) begin
            c = make_cmd(awts_pkg::OP_LOAD, 2'(k));
            if (span != 32767) begin
                c.x_in = 16'($urandom_range(0, 2 * span) - span);
                c.y_in = 16'($urandom_range(0, 2 * span) - span);
                c.z_in = 16'($urandom_range(0, 2 * span) - span);
            end
            send_beat(c, gaps);
        end
    endtask

    task automatic run_directed();
        awts_pkg::cmd_t c;
        c = make_cmd(awts_pkg::OP_SAMPLE, awts_pkg::CORNER_A);
        send_beat(c, 1);                                  // sample on empty table
        send_beat(corner_cmd(awts_pkg::CORNER_C, 100, -50, 7), 1);  // nothing staged
        send_beat(corner_cmd(awts_pkg::CORNER_A, -32768, -32768, -32768), 1);
        send_beat(corner_cmd(awts_pkg::CORNER_B, 32767, -32768, 32767), 1);
        send_beat(corner_cmd(awts_pkg::CORNER_C, -32768, 32767, 32767), 1);
        c = make_cmd(awts_pkg::OP_SAMPLE, awts_pkg::CORNER_A);
        c.select_rand = 16'hFFFF; c.r1_rand = 16'hFFFF; c.r2_rand = 16'hFFFF;
        send_beat(c, 1);
        c.select_rand = 16'h0000; c.r1_rand = 16'h0000; c.r2_rand = 16'h0000;
        send_beat(c, 1);
        c.r1_rand = 16'hFFFF; c.r2_rand = 16'h0000;
        send_beat(c, 1);
        send_beat(corner_cmd(awts_pkg::CORNER_NONE, 1, 2, 3), 1);   // corner three ignored
        send_beat(make_cmd(awts_pkg::OP_NOP, awts_pkg::CORNER_C), 1);
        send_beat(make_cmd(awts_pkg::OP_CLEAR, awts_pkg::CORNER_A), 1);
        // degenerate triangle only: zero total area picks slot 0
        send_beat(corner_cmd(awts_pkg::CORNER_A, 5, 5, 5), 1);
        send_beat(corner_cmd(awts_pkg::CORNER_B, 5, 5, 5), 1);
        send_beat(corner_cmd(awts_pkg::CORNER_C, 5, 5, 5), 1);
        send_beat(make_cmd(awts_pkg::OP_SAMPLE, awts_pkg::CORNER_B), 1);
        send_beat(make_cmd(awts_pkg::OP_CLEAR, awts_pkg::CORNER_B), 1);
    endtask

    // Fill the table with zero-area triangles, then hit it with full loads and samples.
    task automatic run_fill();
        for (int t = 0; t < awts_pkg::TRI_DEPTH; t++) begin
            send_beat(corner_cmd(awts_pkg::CORNER_C, $urandom_range(0, 8),
                                 $urandom_range(0, 8), $urandom_range(0, 8)), 0);
        end
        for (int k = 0; k < 3; k++) send_beat(make_cmd(awts_pkg::OP_LOAD, 2'(k)), 1);
        for (int k = 0; k < 20; k++) send_beat(make_cmd(awts_pkg::OP_SAMPLE, 2'(k)), 1);
        send_beat(make_cmd(awts_pkg::OP_CLEAR, awts_pkg::CORNER_A), 1);
    endtask

    task automatic run_random();
        int                sent;
        int                roll;
        awts_pkg::opcode_t op;
        sent = 0;
        while (sent < NUM_RANDOM) begin
            roll = $urandom_range(0, 99);
            if (roll < 30) begin
                load_random_triangle(1);
                sent += 3;
            end else if (roll < 85) begin
                send_beat(make_cmd(awts_pkg::OP_SAMPLE, 2'($urandom)), 1);
                sent++;
            end else if (roll < 88) begin
                send_beat(make_cmd(awts_pkg::OP_CLEAR, 2'($urandom)), 1);
                sent++;
            end else begin
                op = awts_pkg::opcode_t'($urandom_range(0, 3));
                send_beat(make_cmd(op, 2'($urandom)), 1);
                sent++;
            end
        end
    endtask

    initial
    begin
        sb = new();
        clk = 1'b0;
        rst_n = 1'b0;
        failed = 0;
        stim_done = 0;
        hold_off = 0;
        cmd_ch.valid = 1'b0;
        cmd_ch.data = '0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        hold_off <= 1'b1;
        for (int k = 0; k < 6; k++) send_beat(make_cmd(awts_pkg::OP_NOP, awts_pkg::CORNER_A), 0);
        hold_off <= 1'b0;
        run_fill();
        run_random();
        cmd_ch.valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge clk);
        repeat (200) @(posedge clk);
        if (sb.pending_results.size() != 0) failed = 1;
        if (!failed)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    // Receiver: random stalls, and one long hold-off that backs up the input.
    initial
    begin
        int gap;
        @(posedge rst_n);
        forever
        begin
            if (hold_off) begin
                res_ch.ready <= 1'b0;
                repeat (300) @(posedge clk);
            end
            gap = pick_gap();
            if (gap > 0) begin
                res_ch.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && res_ch.valid && res_ch.ready) begin
            if (sb.check_result(res_ch.data)) failed = 1;
        end
    end

    initial
    begin
        #30000000;
        $display("== FAIL ==");
        $finish;
    end
endmodule
